// ===== hw/rtl/ejim_pkg.sv =====
// shared types and constants of the event interval jitter monitor
package ejim_pkg;

	localparam int CHANNELS      = 32;
	localparam int FIRST_CHANNEL = 1;
	localparam int CH_W          = $clog2(CHANNELS);

	localparam logic [1:0] OP_ARM   = 2'd0;
	localparam logic [1:0] OP_EVENT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_FIRST   = 2'd1;
	localparam logic [1:0] ST_REJECT  = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	typedef enum logic [2:0] {
		KIND_REJECT,
		KIND_ARM,
		KIND_READ,
		KIND_FIRST,
		KIND_MEASURE
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIFF,
		S_MUL_LOW,
		S_MUL_CROSS,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic accept;
		logic calc_interval;
		logic calc_error;
		logic mul_low;
		logic mul_cross;
		logic write;
	} ejim_cmd_t;

	typedef struct packed {
		kind_t kind;
	} ejim_sts_t;

	typedef struct packed {
		logic [63:0] period;
		logic [63:0] stamp;
		logic [63:0] least;
		logic [63:0] greatest;
		logic [63:0] sqsum;
		logic [31:0] count;
	} ejim_rec_t;

endpackage

// ===== hw/rtl/ejim_ctrl.sv =====
// sequencing state machine of the event interval jitter monitor
module ejim_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ejim_pkg::ejim_sts_t sts,
	output logic              busy,
	output ejim_pkg::ejim_cmd_t cmd
);
	import ejim_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
				if (start) begin
					state_d = S_LOAD;
				end
			end
			S_LOAD: begin
				if (sts.kind == KIND_MEASURE) begin
					cmd.calc_interval = 1'b1;
					state_d           = S_DIFF;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_DIFF: begin
				cmd.calc_error = 1'b1;
				state_d        = S_MUL_LOW;
			end
			S_MUL_LOW: begin
				cmd.mul_low = 1'b1;
				state_d     = S_MUL_CROSS;
			end
			S_MUL_CROSS: begin
				cmd.mul_cross = 1'b1;
				state_d       = S_WRITE;
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ejim_dp.sv =====
// channel table, jitter arithmetic and result registers
module ejim_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  ejim_pkg::ejim_cmd_t cmd,
	input  logic [1:0]        opcode,
	input  logic [5:0]        channel,
	input  logic [63:0]       value,
	output ejim_pkg::ejim_sts_t sts,
	output logic              done,
	output logic [1:0]        status,
	output logic [63:0]       deviation,
	output logic [31:0]       event_count,
	output logic [63:0]       min_deviation,
	output logic [63:0]       max_deviation,
	output logic [63:0]       square_sum
);
	import ejim_pkg::*;

	localparam logic [6:0] CH_FIRST = 7'(FIRST_CHANNEL);
	localparam logic [6:0] CH_LIM   = 7'(CHANNELS);

	ejim_rec_t rec_mem [CHANNELS];
	ejim_rec_t rd_q;
	ejim_rec_t rec;
	ejim_rec_t new_rec;

	logic [CHANNELS-1:0] entry_vld_q;
	logic [CHANNELS-1:0] stamp_vld_q;
	logic [CH_W-1:0]     idx_in;
	logic [CH_W-1:0]     idx_q;
	logic                in_range;
	logic                ent_ok_q;
	kind_t               kind_d;
	kind_t               kind_q;
	logic [63:0]         value_q;
	logic [63:0]         interval_q;
	logic [63:0]         err_q;
	logic [63:0]         plow_q;
	logic [31:0]         pcross_q;
	logic [31:0]         mul_b;
	logic [63:0]         product;
	logic                wr_en;
	logic [1:0]          status_d;
	logic [63:0]         dev_d;

	assign idx_in   = channel[CH_W-1:0];
	assign in_range = ({1'b0, channel} >= CH_FIRST) && ({1'b0, channel} < CH_LIM);

	always_comb begin
		kind_d = KIND_REJECT;
		if (in_range) begin
			unique case (opcode)
				OP_ARM:   kind_d = KIND_ARM;
				OP_READ:  kind_d = KIND_READ;
				OP_EVENT: kind_d = stamp_vld_q[idx_in] ? KIND_MEASURE : KIND_FIRST;
				default:  kind_d = KIND_REJECT;
			endcase
		end
	end

	assign sts.kind = kind_q;

	// item capture and table read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_REJECT;
		end else if (cmd.accept) begin
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q    <= idx_in;
			value_q  <= value;
			ent_ok_q <= entry_vld_q[idx_in];
			rd_q     <= rec_mem[idx_in];
		end
	end

	// an entry never written reads as all zero
	assign rec = ent_ok_q ? rd_q : '0;

	// one 32x32 multiplier: low half squared, then low times high
	assign mul_b   = cmd.mul_cross ? err_q[63:32] : err_q[31:0];
	assign product = err_q[31:0] * mul_b;

	// interval, error and partial squares
	always_ff @(posedge clk) begin
		if (cmd.calc_interval) begin
			interval_q <= value_q - rec.stamp;
		end
		if (cmd.calc_error) begin
			err_q <= (interval_q > rec.period) ? (interval_q - rec.period)
			                                   : (rec.period - interval_q);
		end
		if (cmd.mul_low) begin
			plow_q <= product;
		end
		if (cmd.mul_cross) begin
			pcross_q <= product[31:0];
		end
	end

	// next table entry and result
	always_comb begin
		new_rec  = rec;
		wr_en    = 1'b0;
		status_d = ST_REJECT;
		dev_d    = '0;
		case (kind_q)
			KIND_ARM: begin
				new_rec.period   = value_q;
				new_rec.stamp    = '0;
				new_rec.least    = ALL_ONES;
				new_rec.greatest = '0;
				new_rec.sqsum    = '0;
				new_rec.count    = '0;
				wr_en            = 1'b1;
				status_d         = ST_DONE;
			end
			KIND_READ: begin
				status_d = ST_DONE;
			end
			KIND_FIRST: begin
				new_rec.stamp = value_q;
				wr_en         = 1'b1;
				status_d      = ST_FIRST;
			end
			KIND_MEASURE: begin
				new_rec.stamp    = value_q;
				new_rec.least    = (err_q < rec.least) ? err_q : rec.least;
				new_rec.greatest = (err_q > rec.greatest) ? err_q : rec.greatest;
				new_rec.sqsum    = rec.sqsum + plow_q + {pcross_q[30:0], 33'd0};
				new_rec.count    = rec.count + 32'd1;
				wr_en            = 1'b1;
				status_d         = ST_UPDATED;
				dev_d            = err_q;
			end
			default: begin
				new_rec  = '0;
				status_d = ST_REJECT;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.write && wr_en) begin
			rec_mem[idx_q] <= new_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			stamp_vld_q <= '0;
			done        <= 1'b0;
		end else begin
			done <= cmd.write;
			if (cmd.write && wr_en) begin
				entry_vld_q[idx_q] <= 1'b1;
				stamp_vld_q[idx_q] <= (kind_q != KIND_ARM);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			status        <= status_d;
			deviation     <= dev_d;
			event_count   <= new_rec.count;
			min_deviation <= new_rec.least;
			max_deviation <= new_rec.greatest;
			square_sum    <= new_rec.sqsum;
		end
	end

endmodule

// ===== hw/rtl/event_interval_jitter_monitor_unit.sv =====
// top level of the event interval jitter monitor
// An item is taken at a clock edge with start high and busy low; its one result appears
// on the result ports for a single cycle with done high and cannot be held off. Arm, read
// and rejected items go from accept through the load and write states to done; an event
// that measures an interval also takes the interval and error subtracts and the two
// passes through the shared 32x32 multiplier that build the low 64 bits of the square.
// busy drops in the cycle done is shown, so a new item may be started then. The channel
// table comes out of reset empty, with no clearing pass.
module event_interval_jitter_monitor_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [5:0]  channel,
	input  logic [63:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] deviation,
	output logic [31:0] event_count,
	output logic [63:0] min_deviation,
	output logic [63:0] max_deviation,
	output logic [63:0] square_sum
);
	import ejim_pkg::*;

	ejim_cmd_t cmd;
	ejim_sts_t sts;

	ejim_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	ejim_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.opcode        (opcode),
		.channel       (channel),
		.value         (value),
		.sts           (sts),
		.done          (done),
		.status        (status),
		.deviation     (deviation),
		.event_count   (event_count),
		.min_deviation (min_deviation),
		.max_deviation (max_deviation),
		.square_sum    (square_sum)
	);

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not start work");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_REJECT) |-> (deviation == '0 && event_count == '0
			&& min_deviation == '0 && max_deviation == '0 && square_sum == '0))
		else $error("rejected item returned statistics");
	a_dev_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && deviation != '0) |-> (status == ST_UPDATED))
		else $error("deviation on an item that measured no interval");
`endif

endmodule

// ===== tb/sv/event_interval_jitter_monitor_unit_tb.sv =====
// self-checking testbench of the event interval jitter monitor: directed table, random items
module event_interval_jitter_monitor_unit_tb;
	import ejim_pkg::*;

	localparam logic [1:0]  OP_UNUSED      = 2'd3;
	localparam int          DIRECTED_ROWS  = 25;
	localparam int          RANDOM_ITEMS   = 1400;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          DRAIN_CYCLES   = 12;
	localparam int          REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] deviation;
		logic [31:0] count;
		logic [63:0] least;
		logic [63:0] greatest;
		logic [63:0] sqsum;
	} jitter_result_t;

	typedef struct packed {
		logic [1:0]     op;
		logic [5:0]     ch;
		logic [63:0]    val;
		logic           typed;
		jitter_result_t typed_res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [5:0]  channel;
	logic [63:0] value;
	logic        done;
	logic [1:0]  status;
	logic [63:0] deviation;
	logic [31:0] event_count;
	logic [63:0] min_deviation;
	logic [63:0] max_deviation;
	logic [63:0] square_sum;

	event_interval_jitter_monitor_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.channel      (channel),
		.value        (value),
		.done         (done),
		.status       (status),
		.deviation    (deviation),
		.event_count  (event_count),
		.min_deviation(min_deviation),
		.max_deviation(max_deviation),
		.square_sum   (square_sum)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predictor copy of the channel table
	logic [63:0] model_period   [CHANNELS];
	logic [63:0] model_stamp    [CHANNELS];
	logic        model_stamped  [CHANNELS];
	logic [63:0] model_least    [CHANNELS];
	logic [63:0] model_greatest [CHANNELS];
	logic [63:0] model_sqsum    [CHANNELS];
	logic [31:0] model_count    [CHANNELS];

	// generator view of each channel's timing
	logic [63:0] gen_period [CHANNELS];
	logic [63:0] gen_stamp  [CHANNELS];

	jitter_result_t pending_readouts[$];
	jitter_result_t predicted;
	jitter_result_t observed;
	jitter_result_t wanted;
	stim_row_t      directed_rows[DIRECTED_ROWS];
	logic           row_typed;
	jitter_result_t row_typed_res;
	int unsigned    mismatch_count;
	int unsigned    stall_cycles;
	int unsigned    burst_left;

	function automatic jitter_result_t apply_to_channel_table(input logic [1:0] op,
			input logic [5:0] ch, input logic [63:0] val);
		jitter_result_t res;
		logic [63:0]    span;
		logic [63:0]    err;
		logic [63:0]    sq;
		res = '0;
		if (op == OP_UNUSED || ch < FIRST_CHANNEL || ch >= CHANNELS) begin
			res.status = ST_REJECT;
			return res;
		end
		case (op)
			OP_ARM: begin
				model_period[ch]   = val;
				model_stamp[ch]    = '0;
				model_stamped[ch]  = 1'b0;
				model_least[ch]    = ALL_ONES;
				model_greatest[ch] = '0;
				model_sqsum[ch]    = '0;
				model_count[ch]    = '0;
				res.status         = ST_DONE;
			end
			OP_READ: begin
				res.status = ST_DONE;
			end
			default: begin
				if (!model_stamped[ch]) begin
					model_stamp[ch]   = val;
					model_stamped[ch] = 1'b1;
					res.status        = ST_FIRST;
				end else begin
					span = val - model_stamp[ch];
					err  = (span > model_period[ch]) ? span - model_period[ch]
						: model_period[ch] - span;
					sq   = err * err;
					if (err < model_least[ch])
						model_least[ch] = err;
					if (err > model_greatest[ch])
						model_greatest[ch] = err;
					model_sqsum[ch] = model_sqsum[ch] + sq;
					model_count[ch] = model_count[ch] + 32'd1;
					model_stamp[ch] = val;
					res.status      = ST_UPDATED;
					res.deviation   = err;
				end
			end
		endcase
		res.count    = model_count[ch];
		res.least    = model_least[ch];
		res.greatest = model_greatest[ch];
		res.sqsum    = model_sqsum[ch];
		return res;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (burst_left != 0) begin
			burst_left = burst_left - 1;
			return 0;
		end
		if (r < 4) begin
			burst_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic issue_item(input logic [1:0] op, input logic [5:0] ch,
			input logic [63:0] val, input logic typed, input jitter_result_t typed_res);
		start         <= 1'b1;
		opcode        <= op;
		channel       <= ch;
		value         <= val;
		row_typed     <= typed;
		row_typed_res <= typed_res;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic hold_off(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// prediction at accept, checking at done
	always @(posedge clk) begin
		if (!arst_n) begin
			mismatch_count = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				model_period[i]   = '0;
				model_stamp[i]    = '0;
				model_stamped[i]  = 1'b0;
				model_least[i]    = '0;
				model_greatest[i] = '0;
				model_sqsum[i]    = '0;
				model_count[i]    = '0;
			end
		end
		if (arst_n && start && !busy) begin
			predicted = apply_to_channel_table(opcode, channel, value);
			if (row_typed)
				pending_readouts.push_back(row_typed_res);
			else
				pending_readouts.push_back(predicted);
		end
		if (arst_n && done) begin
			observed = '{status, deviation, event_count, min_deviation, max_deviation,
				square_sum};
			if (pending_readouts.size() == 0) begin
				mismatch_count = mismatch_count + 1;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: status %0d dev %h", status, deviation);
			end else begin
				wanted = pending_readouts.pop_front();
				if (observed.status !== wanted.status || observed.deviation !== wanted.deviation
						|| observed.count !== wanted.count || observed.least !== wanted.least
						|| observed.greatest !== wanted.greatest
						|| observed.sqsum !== wanted.sqsum) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("mismatch exp: st %0d dev %h cnt %h min %h max %h sq %h",
							wanted.status, wanted.deviation, wanted.count, wanted.least,
							wanted.greatest, wanted.sqsum);
						$display("         got: st %0d dev %h cnt %h min %h max %h sq %h",
							observed.status, observed.deviation, observed.count,
							observed.least, observed.greatest, observed.sqsum);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0]  op;
		logic [5:0]  ch;
		logic [63:0] val;
		int unsigned r;
		arst_n         = 1'b0;
		start          = 1'b0;
		opcode         = OP_READ;
		channel        = '0;
		value          = '0;
		row_typed      = 1'b0;
		row_typed_res  = '0;
		burst_left     = 0;
		for (int i = 0; i < CHANNELS; i++) begin
			gen_period[i]     = '0;
			gen_stamp[i]      = '0;
		end
		directed_rows = '{
			'{OP_READ,   6'd5,  64'd0,    1'b1, '{ST_DONE,   64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd0,  64'd7,    1'b1, '{ST_REJECT, 64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_ARM,    6'd32, 64'd100,  1'b1, '{ST_REJECT, 64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_READ,   6'd63, ALL_ONES, 1'b1, '{ST_REJECT, 64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_UNUSED, 6'd5,  ALL_ONES, 1'b1, '{ST_REJECT, 64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd5,  64'd0,    1'b1, '{ST_FIRST,  64'd0, 32'd0, 64'd0, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd5,  64'd1000, 1'b0, '0},
			'{OP_ARM,    6'd1,  64'd100,  1'b1, '{ST_DONE, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd1,  64'd0,    1'b1, '{ST_FIRST, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd1,  64'd100,  1'b0, '0},
			'{OP_EVENT,  6'd1,  64'd250,  1'b0, '0},
			'{OP_EVENT,  6'd1,  64'd300,  1'b0, '0},
			'{OP_EVENT,  6'd1,  64'd10,   1'b0, '0},
			'{OP_READ,   6'd1,  64'd0,    1'b0, '0},
			'{OP_ARM,    6'd31, ALL_ONES, 1'b1, '{ST_DONE, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd31, ALL_ONES, 1'b1, '{ST_FIRST, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd31, 64'hffff_ffff_ffff_fffe, 1'b0, '0},
			'{OP_EVENT,  6'd31, 64'h8000_0000_0000_0000, 1'b0, '0},
			'{OP_ARM,    6'd2,  64'd0,    1'b0, '0},
			'{OP_EVENT,  6'd2,  64'h1234_5678_9abc_def0, 1'b0, '0},
			'{OP_EVENT,  6'd2,  64'h1234_5679_9abc_def1, 1'b0, '0},
			'{OP_READ,   6'd31, 64'd0,    1'b0, '0},
			'{OP_ARM,    6'd1,  64'd0,    1'b1, '{ST_DONE, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_READ,   6'd1,  ALL_ONES, 1'b1, '{ST_DONE, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}},
			'{OP_EVENT,  6'd1,  64'd5,    1'b1, '{ST_FIRST, 64'd0, 32'd0, ALL_ONES, 64'd0, 64'd0}}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			issue_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].val,
				directed_rows[i].typed, directed_rows[i].typed_res);
			hold_off(pick_gap());
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			r  = $urandom_range(0, 99);
			ch = 6'($urandom_range(FIRST_CHANNEL, CHANNELS - 1));
			if (r < 6) begin
				op = OP_ARM;
				case ($urandom_range(0, 3))
					0: val = '0;
					1: val = {$urandom, $urandom};
					default: val = 64'($urandom_range(1, 100000));
				endcase
				gen_period[ch] = val;
				gen_stamp[ch]  = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
					: 64'($urandom_range(0, 1000));
			end else if (r < 12) begin
				op  = OP_READ;
				val = {$urandom, $urandom};
			end else if (r < 17) begin
				// noise: any opcode, any channel
				op  = 2'($urandom_range(0, 3));
				ch  = 6'($urandom_range(0, 63));
				val = {$urandom, $urandom};
			end else if (r < 21) begin
				op  = OP_EVENT;
				val = {$urandom, $urandom};
				gen_stamp[ch] = val;
			end else begin
				op  = OP_EVENT;
				val = gen_stamp[ch] + gen_period[ch] + 64'($urandom_range(0, 400)) - 64'd200;
				gen_stamp[ch] = val;
			end
			issue_item(op, ch, val, 1'b0, '0);
			hold_off(pick_gap());
		end
		start <= 1'b0;

		while (pending_readouts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_readouts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== event_interval_jitter_monitor_unit.f =====
hw/rtl/ejim_pkg.sv
hw/rtl/ejim_ctrl.sv
hw/rtl/ejim_dp.sv
hw/rtl/event_interval_jitter_monitor_unit.sv
tb/sv/event_interval_jitter_monitor_unit_tb.sv
